// File: rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

   localparam int CHANNEL_BITS = 10;
   localparam int HUE_BITS     = 10;
   localparam int SAT_BITS     = 9;
   localparam int VAL_BITS     = 10;

   // saturation scale is 2**SAT_BITS - 1, so delta*scale = (delta << SAT_BITS) - delta
   localparam int DIV_STEPS = SAT_BITS;
   localparam int NUM_BITS  = CHANNEL_BITS + SAT_BITS;

   localparam int HUE_SCALE = 60;
   localparam int HUE_GREEN = 120;
   localparam int HUE_BLUE  = 240;
   localparam int HUE_WRAP  = 360;

   // pipeline slots: input, max/min, delta/diff, dividend, divider steps, output
   localparam int ST_IN   = 0;
   localparam int ST_EXT  = 1;
   localparam int ST_DIFF = 2;
   localparam int ST_NUM  = 3;
   localparam int ST_DIV  = 4;
   localparam int ST_OUT  = ST_DIV + DIV_STEPS;
   localparam int STAGES  = ST_OUT + 1;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] mx;
      sector_type              sector;
      logic                    neg;
      logic                    grey;
      logic                    black;
   } side_type;

endpackage

// File: rtl/rgbhsv_div.sv
module rgbhsv_div import rgbhsv_pkg::*; (
   input  logic                    clock,
   input  logic [DIV_STEPS-1:0]    step_en,
   input  logic [NUM_BITS-1:0]     num,
   input  logic [CHANNEL_BITS-1:0] den,
   output logic [DIV_STEPS-1:0]    quo
);

   logic [NUM_BITS-1:0]     rem_ff [DIV_STEPS-1];
   logic [CHANNEL_BITS-1:0] den_ff [DIV_STEPS-1];
   logic [DIV_STEPS-1:0]    quo_ff [DIV_STEPS];

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [NUM_BITS-1:0]     rem_prev;
      logic [CHANNEL_BITS-1:0] den_prev;
      logic [DIV_STEPS-1:0]    quo_prev;
      logic [NUM_BITS:0]       trial;
      logic [DIV_STEPS-1:0]    quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign trial = {1'b0, rem_prev}
                   - ({1'b0, NUM_BITS'(den_prev)} << (DIV_STEPS - 1 - j));

      always_comb begin
         quo_in = quo_prev;
         quo_in[DIV_STEPS-1-j] = ~trial[NUM_BITS];
      end

      always_ff @(posedge clock) begin
         if (step_en[j]) begin
            quo_ff[j] <= quo_in;
         end
      end

      if (j < DIV_STEPS - 1) begin : g_rem
         logic [NUM_BITS-1:0] rem_in;

         // keep the partial remainder when the trial went negative
         assign rem_in = trial[NUM_BITS] ? rem_prev : trial[NUM_BITS-1:0];

         always_ff @(posedge clock) begin
            if (step_en[j]) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

// File: rtl/rgb_to_hsv_converter.sv
// Converts one RGB pixel per clock while req_stall is low into hue (degrees, -1 for
// grey), saturation (0..511) and value (largest channel). The block is a 14-stage
// pipeline: input register, max/min select, delta and sector difference, dividend
// forming, nine restoring divide stages that resolve one quotient bit each (saturation
// and hue divide side by side), and the output register. A new request is taken every
// cycle while req_stall is low; a stall on the result side holds a stage only when every
// slot from it to the output is full, so empty slots still fill from the request side.
module rgb_to_hsv_converter import rgbhsv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CHANNEL_BITS-1:0]    req_red,
   input  logic [CHANNEL_BITS-1:0]    req_green,
   input  logic [CHANNEL_BITS-1:0]    req_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [HUE_BITS-1:0] rsp_hue,
   output logic [SAT_BITS-1:0]        rsp_saturation,
   output logic [VAL_BITS-1:0]        rsp_brightness
);

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_en;

   // a stage loads when the result is taken or any slot at or after it is empty
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         stage_en[k] = ~rsp_stall | ~(&(valid_ff | ~({STAGES{1'b1}} << k)));
      end
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            valid_in[k] = stage_en[k] ? req_valid : valid_ff[k];
         end else begin
            valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~stage_en[ST_IN];
   assign rsp_valid = valid_ff[ST_OUT];

   // input register
   logic [CHANNEL_BITS-1:0] r0_ff, g0_ff, b0_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         r0_ff <= req_red;
         g0_ff <= req_green;
         b0_ff <= req_blue;
      end
   end

   // max, min and hue sector; red wins ties over green, green over blue
   logic [CHANNEL_BITS-1:0] mx1_in, mn1_in;
   sector_type              sector1_in;
   logic [CHANNEL_BITS-1:0] r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   sector_type              sector1_ff;

   always_comb begin
      if (r0_ff >= g0_ff && r0_ff >= b0_ff) begin
         sector1_in = SECTOR_RED;
         mx1_in     = r0_ff;
      end else if (g0_ff >= b0_ff) begin
         sector1_in = SECTOR_GREEN;
         mx1_in     = g0_ff;
      end else begin
         sector1_in = SECTOR_BLUE;
         mx1_in     = b0_ff;
      end
      if (r0_ff <= g0_ff && r0_ff <= b0_ff) begin
         mn1_in = r0_ff;
      end else if (g0_ff <= b0_ff) begin
         mn1_in = g0_ff;
      end else begin
         mn1_in = b0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_EXT]) begin
         r1_ff      <= r0_ff;
         g1_ff      <= g0_ff;
         b1_ff      <= b0_ff;
         mx1_ff     <= mx1_in;
         mn1_ff     <= mn1_in;
         sector1_ff <= sector1_in;
      end
   end

   // delta and signed sector difference
   logic [CHANNEL_BITS-1:0]        delta2_in;
   logic signed [CHANNEL_BITS:0]   diff2_in;
   logic [CHANNEL_BITS-1:0]        mx2_ff, delta2_ff;
   logic signed [CHANNEL_BITS:0]   diff2_ff;
   sector_type                     sector2_ff;

   always_comb begin
      delta2_in = mx1_ff - mn1_ff;
      case (sector1_ff)
         SECTOR_RED:   diff2_in = $signed({1'b0, g1_ff}) - $signed({1'b0, b1_ff});
         SECTOR_GREEN: diff2_in = $signed({1'b0, b1_ff}) - $signed({1'b0, r1_ff});
         SECTOR_BLUE:  diff2_in = $signed({1'b0, r1_ff}) - $signed({1'b0, g1_ff});
         default:      diff2_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_DIFF]) begin
         mx2_ff     <= mx1_ff;
         delta2_ff  <= delta2_in;
         diff2_ff   <= diff2_in;
         sector2_ff <= sector1_ff;
      end
   end

   // dividends: delta*511 over max, 60*|diff| over delta
   logic [CHANNEL_BITS-1:0] absd3;
   logic [NUM_BITS-1:0]     sat_num3_in, hue_num3_in;
   logic [NUM_BITS-1:0]     sat_num3_ff, hue_num3_ff;
   logic [CHANNEL_BITS-1:0] sat_den3_ff, hue_den3_ff;
   side_type                side3_in, side3_ff;

   always_comb begin
      absd3       = diff2_ff[CHANNEL_BITS] ? CHANNEL_BITS'(-diff2_ff)
                                           : CHANNEL_BITS'(diff2_ff);
      sat_num3_in = (NUM_BITS'(delta2_ff) << SAT_BITS) - NUM_BITS'(delta2_ff);
      hue_num3_in = NUM_BITS'(absd3) * NUM_BITS'(HUE_SCALE);
      side3_in.mx     = mx2_ff;
      side3_in.sector = sector2_ff;
      side3_in.neg    = diff2_ff[CHANNEL_BITS];
      side3_in.grey   = (delta2_ff == '0);
      side3_in.black  = (mx2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_NUM]) begin
         sat_num3_ff <= sat_num3_in;
         hue_num3_ff <= hue_num3_in;
         sat_den3_ff <= mx2_ff;
         hue_den3_ff <= delta2_ff;
         side3_ff    <= side3_in;
      end
   end

   // divider stages
   logic [DIV_STEPS-1:0] sat_quo, hue_quo;
   side_type             side_ff [DIV_STEPS];

   rgbhsv_div u_sat_div (
      .clock   (clock),
      .step_en (stage_en[ST_DIV +: DIV_STEPS]),
      .num     (sat_num3_ff),
      .den     (sat_den3_ff),
      .quo     (sat_quo)
   );

   rgbhsv_div u_hue_div (
      .clock   (clock),
      .step_en (stage_en[ST_DIV +: DIV_STEPS]),
      .num     (hue_num3_ff),
      .den     (hue_den3_ff),
      .quo     (hue_quo)
   );

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (stage_en[ST_DIV+j]) begin
            side_ff[j] <= (j == 0) ? side3_ff : side_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // output stage: sector offset, wrap negative hue, mask grey and black
   side_type                   side_out;
   logic signed [HUE_BITS:0]   hue_off, hue_q, hue_sum;
   logic signed [HUE_BITS-1:0] hue_in, hue_ff;
   logic [SAT_BITS-1:0]        sat_in, sat_ff;
   logic [VAL_BITS-1:0]        val_ff;

   always_comb begin
      side_out = side_ff[DIV_STEPS-1];
      hue_q    = $signed((HUE_BITS+1)'(hue_quo));
      case (side_out.sector)
         SECTOR_RED:   hue_off = '0;
         SECTOR_GREEN: hue_off = (HUE_BITS+1)'(HUE_GREEN);
         SECTOR_BLUE:  hue_off = (HUE_BITS+1)'(HUE_BLUE);
         default:      hue_off = '0;
      endcase
      hue_sum = side_out.neg ? hue_off - hue_q : hue_off + hue_q;
      if (hue_sum[HUE_BITS]) begin
         hue_sum = hue_sum + (HUE_BITS+1)'(HUE_WRAP);
      end
      hue_in = side_out.grey ? '1 : hue_sum[HUE_BITS-1:0];
      sat_in = side_out.black ? '0 : sat_quo;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= VAL_BITS'(side_out.mx);
      end
   end

   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = val_ff;

endmodule

// File: rtl/rgbhsv_check.sv
module rgbhsv_check import rgbhsv_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [HUE_BITS-1:0] rsp_hue,
   input logic [SAT_BITS-1:0]        rsp_saturation,
   input logic [VAL_BITS-1:0]        rsp_brightness
);

   logic hue_undef;

   assign hue_undef = (rsp_hue == '1);

   // grey pixel: no hue and no saturation
   a_grey_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hue_undef |-> rsp_saturation == '0)
      else $error("grey pixel with nonzero saturation");

   // black pixel is grey too
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brightness == '0 |-> hue_undef && rsp_saturation == '0)
      else $error("black pixel with hue or saturation");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hue_undef || (!rsp_hue[HUE_BITS-1] && rsp_hue < HUE_BITS'(HUE_WRAP)))
      else $error("hue out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("stalled response changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rgb_to_hsv_converter rgbhsv_check u_rgbhsv_check (.*);
